// ===== rtl/core/bstr_pkg.sv =====
// ----------------------------------------------------------------------------
// bstr_pkg: shared types and constants for the beam-spot resolution unit
// Field widths, status codes, register indexes and the stage tag type.
// ----------------------------------------------------------------------------
package bstr_pkg;

  localparam int DIR_W   = 16;
  localparam int VAR_W   = 32;
  localparam int SQ_W    = 31;   // magnitude squared, at most 2^30
  localparam int DEN_W   = 32;   // sum of squares, at most 2^31
  localparam int NUM_W   = 63;   // weighted numerator, below 2^63
  localparam int QUO_W   = 40;   // floor(256*N/D), below 2^40
  localparam int ROOT_W  = 20;   // floor(sqrt(Q))
  localparam int SREM_W  = 22;   // square root partial remainder
  localparam int RMS_W   = 32;
  localparam int STAT_W  = 2;

  localparam logic [VAR_W-1:0] VAR_RESET = VAR_W'(100);
  localparam logic [RMS_W-1:0] RMS_MAX   = '1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NODIR = 2'd1;
  localparam logic [STAT_W-1:0] ST_CHI2  = 2'd2;

  // configuration register indexes
  localparam logic REG_VAR_X = 1'b0;
  localparam logic REG_VAR_Y = 1'b1;

  // control carried beside the data through every stage
  typedef struct packed {
    logic                valid;
    logic [STAT_W-1:0]   status;
  } tag_t;

endpackage

// ===== rtl/core/beam_spot_track_resolution_unit.sv =====
// ----------------------------------------------------------------------------
// beam_spot_track_resolution_unit: beam-spot resolution along a track
// rms = floor(16*sqrt((x^2*var_y + y^2*var_x)/(x^2+y^2))), pipelined.
// ----------------------------------------------------------------------------
//  channel   | dir | content
//  s_axis    | in  | tdata[15:0] dir_x, tdata[31:16] dir_y
//  m_axis    | out | tdata[31:0] rms, tdata[33:32] status, rest zero
//  cfg       | in  | cfg_we, cfg_index (0 var_x, 1 var_y), cfg_data
//
//  Pipeline: 3 front stages, 40 divider stages, 20 root stages.
//  One transaction per cycle is taken while the output is empty or m_tready is high.
//  The whole pipeline advances together; a stall on m_axis freezes every
//  stage and drops s_tready, so nothing is lost or repeated.
//  rst is synchronous: it clears all valid bits and loads var_x/var_y = 100.
// ----------------------------------------------------------------------------
module beam_spot_track_resolution_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,   // dir_x[15:0], dir_y[31:16]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [39:0]                m_tdata,   // rms[31:0], status[33:32], zero
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [bstr_pkg::VAR_W-1:0] cfg_data
);

  logic                          en;
  logic [bstr_pkg::VAR_W-1:0]    var_x, var_y;
  bstr_pkg::tag_t                front_tag, div_tag, out_tag;
  logic [bstr_pkg::NUM_W-1:0]    num;
  logic [bstr_pkg::DEN_W-1:0]    den;
  logic [bstr_pkg::QUO_W-1:0]    quo;
  logic [bstr_pkg::ROOT_W-1:0]   root;
  logic [bstr_pkg::RMS_W-1:0]    rms;

  // global advance: output empty or being taken
  assign en       = !out_tag.valid || m_tready;
  assign s_tready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      var_x <= bstr_pkg::VAR_RESET;
      var_y <= bstr_pkg::VAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bstr_pkg::REG_VAR_X: var_x <= cfg_data;
        bstr_pkg::REG_VAR_Y: var_y <= cfg_data;
        default: ;
      endcase
    end
  end

  bstr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(s_tvalid),
    .dir_x   (s_tdata[15:0]),
    .dir_y   (s_tdata[31:16]),
    .var_x   (var_x),
    .var_y   (var_y),
    .tag_out (front_tag),
    .num     (num),
    .den     (den)
  );

  bstr_div u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .tag_in (front_tag),
    .num    (num),
    .den    (den),
    .tag_out(div_tag),
    .quo    (quo)
  );

  bstr_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .tag_in (div_tag),
    .quo    (quo),
    .tag_out(out_tag),
    .root   (root)
  );

  // result select for the special cases
  always_comb begin
    case (out_tag.status)
      bstr_pkg::ST_NODIR: rms = bstr_pkg::RMS_MAX;
      bstr_pkg::ST_CHI2:  rms = '0;
      default:            rms = {{(bstr_pkg::RMS_W-bstr_pkg::ROOT_W){1'b0}}, root};
    endcase
  end

  assign m_tvalid = out_tag.valid;
  assign m_tdata  = {6'b000000, out_tag.status, rms};

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(div_tag) && $stable(quo))
    else $error("divider moved during stall");
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_tag.status == bstr_pkg::ST_OK) |-> (m_tdata[31:20] == 12'h000))
    else $error("root wider than 20 bits");
  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");
`endif

endmodule

// ===== rtl/core/bstr_front.sv =====
// ----------------------------------------------------------------------------
// bstr_front: squares, weighting products and numerator sum
// Three stages: magnitudes squared, products with variances, sum and status.
// ----------------------------------------------------------------------------
module bstr_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [bstr_pkg::DIR_W-1:0] dir_x,
  input  logic signed [bstr_pkg::DIR_W-1:0] dir_y,
  input  logic [bstr_pkg::VAR_W-1:0]   var_x,
  input  logic [bstr_pkg::VAR_W-1:0]   var_y,
  output bstr_pkg::tag_t               tag_out,
  output logic [bstr_pkg::NUM_W-1:0]   num,
  output logic [bstr_pkg::DEN_W-1:0]   den
);

  logic [bstr_pkg::DIR_W-1:0] mag_x, mag_y;
  logic [bstr_pkg::SQ_W-1:0]  sq_x, sq_y;
  logic [bstr_pkg::DEN_W-1:0] den1, den2;
  logic [bstr_pkg::NUM_W-2:0] prod_x, prod_y;
  logic                       v1, v2;
  logic [bstr_pkg::NUM_W-1:0] num_sum;

  // magnitudes; -32768 gives 32768 as an unsigned 16-bit value
  assign mag_x = dir_x[bstr_pkg::DIR_W-1] ? (~dir_x + bstr_pkg::DIR_W'(1)) : dir_x;
  assign mag_y = dir_y[bstr_pkg::DIR_W-1] ? (~dir_y + bstr_pkg::DIR_W'(1)) : dir_y;

  // stage 1: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      sq_x <= bstr_pkg::SQ_W'(mag_x) * bstr_pkg::SQ_W'(mag_x);
      sq_y <= bstr_pkg::SQ_W'(mag_y) * bstr_pkg::SQ_W'(mag_y);
    end
  end

  assign den1 = {1'b0, sq_x} + {1'b0, sq_y};

  // stage 2: cross-weighted products
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      prod_x <= (bstr_pkg::NUM_W-1)'(sq_x) * (bstr_pkg::NUM_W-1)'(var_y);
      prod_y <= (bstr_pkg::NUM_W-1)'(sq_y) * (bstr_pkg::NUM_W-1)'(var_x);
      den2   <= den1;
    end
  end

  assign num_sum = {1'b0, prod_x} + {1'b0, prod_y};

  // stage 3: numerator and special cases
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else if (en) begin
      tag_out.valid <= v2;
    end
    if (en) begin
      num <= num_sum;
      den <= den2;
      if (den2 == '0) begin
        tag_out.status <= bstr_pkg::ST_NODIR;
      end else if (num_sum == '0) begin
        tag_out.status <= bstr_pkg::ST_CHI2;
      end else begin
        tag_out.status <= bstr_pkg::ST_OK;
      end
    end
  end

endmodule

// ===== rtl/core/bstr_div.sv =====
// ----------------------------------------------------------------------------
// bstr_div: pipelined restoring divider, one quotient bit per stage
// Computes floor((N << 8) / D) as a 40-bit quotient over 40 stages.
// ----------------------------------------------------------------------------
module bstr_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  bstr_pkg::tag_t               tag_in,
  input  logic [bstr_pkg::NUM_W-1:0]   num,
  input  logic [bstr_pkg::DEN_W-1:0]   den,
  output bstr_pkg::tag_t               tag_out,
  output logic [bstr_pkg::QUO_W-1:0]   quo
);

  localparam int STEPS = bstr_pkg::QUO_W;

  bstr_pkg::tag_t             tag [1:STEPS];
  logic [bstr_pkg::DEN_W-1:0] rem [1:STEPS];
  logic [bstr_pkg::DEN_W-1:0] dv  [1:STEPS];
  logic [bstr_pkg::QUO_W-1:0] wrd [1:STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    bstr_pkg::tag_t             t_src;
    logic [bstr_pkg::DEN_W-1:0] r_src, d_src;
    logic [bstr_pkg::QUO_W-1:0] w_src;
    logic [bstr_pkg::DEN_W:0]   shifted, diff;
    logic                       take;

    // first stage loads the top dividend bits, which stay below D
    if (i == 0) begin : g_load
      assign t_src = tag_in;
      assign r_src = {1'b0, num[bstr_pkg::NUM_W-1:bstr_pkg::QUO_W-8]};
      assign w_src = {num[bstr_pkg::QUO_W-9:0], 8'h00};
      assign d_src = den;
    end else begin : g_chain
      assign t_src = tag[i];
      assign r_src = rem[i];
      assign w_src = wrd[i];
      assign d_src = dv[i];
    end

    // trial subtract of the divisor
    assign shifted = {r_src, w_src[bstr_pkg::QUO_W-1]};
    assign diff    = shifted - {1'b0, d_src};
    assign take    = (shifted >= {1'b0, d_src});

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[i+1].valid <= 1'b0;
      end else if (en) begin
        tag[i+1].valid <= t_src.valid;
      end
      if (en) begin
        tag[i+1].status <= t_src.status;
        rem[i+1] <= take ? diff[bstr_pkg::DEN_W-1:0] : shifted[bstr_pkg::DEN_W-1:0];
        wrd[i+1] <= {w_src[bstr_pkg::QUO_W-2:0], take};
        dv[i+1]  <= d_src;
      end
    end
  end

  assign tag_out = tag[STEPS];
  assign quo     = wrd[STEPS];

endmodule

// ===== rtl/core/bstr_sqrt.sv =====
// ----------------------------------------------------------------------------
// bstr_sqrt: pipelined digit-by-digit integer square root
// One root bit per stage over 20 stages; the last stage is the output register.
// ----------------------------------------------------------------------------
module bstr_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  bstr_pkg::tag_t                tag_in,
  input  logic [bstr_pkg::QUO_W-1:0]    quo,
  output bstr_pkg::tag_t                tag_out,
  output logic [bstr_pkg::ROOT_W-1:0]   root
);

  localparam int STEPS = bstr_pkg::ROOT_W;

  bstr_pkg::tag_t              tag [1:STEPS];
  logic [bstr_pkg::SREM_W-1:0] rem [1:STEPS];
  logic [bstr_pkg::ROOT_W-1:0] rt  [1:STEPS];
  logic [bstr_pkg::QUO_W-1:0]  wrd [1:STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    bstr_pkg::tag_t              t_src;
    logic [bstr_pkg::SREM_W-1:0] r_src;
    logic [bstr_pkg::ROOT_W-1:0] q_src;
    logic [bstr_pkg::QUO_W-1:0]  w_src;
    logic [bstr_pkg::SREM_W+1:0] shifted, trial, diff;
    logic                        take;

    if (i == 0) begin : g_load
      assign t_src = tag_in;
      assign r_src = '0;
      assign q_src = '0;
      assign w_src = quo;
    end else begin : g_chain
      assign t_src = tag[i];
      assign r_src = rem[i];
      assign q_src = rt[i];
      assign w_src = wrd[i];
    end

    // bring down two bits, try root*4+1
    assign shifted = {r_src, w_src[bstr_pkg::QUO_W-1:bstr_pkg::QUO_W-2]};
    assign trial   = {2'b00, q_src, 2'b01};
    assign diff    = shifted - trial;
    assign take    = (shifted >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        tag[i+1].valid <= 1'b0;
      end else if (en) begin
        tag[i+1].valid <= t_src.valid;
      end
      if (en) begin
        tag[i+1].status <= t_src.status;
        rem[i+1] <= take ? diff[bstr_pkg::SREM_W-1:0] : shifted[bstr_pkg::SREM_W-1:0];
        rt[i+1]  <= {q_src[bstr_pkg::ROOT_W-2:0], take};
        wrd[i+1] <= {w_src[bstr_pkg::QUO_W-3:0], 2'b00};
      end
    end
  end

  assign tag_out = tag[STEPS];
  assign root    = rt[STEPS];

endmodule
